// ----- rtl/abs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package abs_pkg;

  localparam int MODE_W     = 2;
  localparam int LO_W       = 64;
  localparam int MID_W      = 64;
  localparam int HI_W       = 32;
  localparam int PL_W       = LO_W + MID_W + HI_W;
  localparam int PL_BYTES   = PL_W / 8;
  localparam int CHK_W      = 13;
  localparam int TIMEOUT_W  = 16;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd100;

  localparam logic [MODE_W-1:0] MODE_MSG  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ACK  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TICK = 2'd2;

  typedef logic [PL_W-1:0]      payload_t;
  typedef logic [CHK_W-1:0]     chk_t;
  typedef logic [TIMEOUT_W-1:0] ticks_t;

  typedef struct packed {
    payload_t pl;
    chk_t     chk;
  } entry_t;

endpackage

`default_nettype wire

// ----- rtl/abs_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface abs_in_if;
  logic                        valid;
  logic                        ready;
  logic [abs_pkg::MODE_W-1:0]  mode;
  logic [abs_pkg::LO_W-1:0]    payload_lo;
  logic [abs_pkg::MID_W-1:0]   payload_mid;
  logic [abs_pkg::HI_W-1:0]    payload_hi;
  logic                        ack_number;
  logic                        seq_number;
  logic [abs_pkg::CHK_W-1:0]   checksum_in;

  modport source (
    output valid, mode, payload_lo, payload_mid, payload_hi,
           ack_number, seq_number, checksum_in,
    input  ready
  );
  modport sink (
    input  valid, mode, payload_lo, payload_mid, payload_hi,
           ack_number, seq_number, checksum_in,
    output ready
  );
endinterface

interface abs_out_if;
  logic                        valid;
  logic                        ready;
  logic                        send_valid;
  logic [abs_pkg::LO_W-1:0]    out_payload_lo;
  logic [abs_pkg::MID_W-1:0]   out_payload_mid;
  logic [abs_pkg::HI_W-1:0]    out_payload_hi;
  logic                        out_seq;
  logic                        out_ack;
  logic [abs_pkg::CHK_W-1:0]   out_checksum;
  logic                        dropped;
  logic                        waiting;

  modport source (
    output valid, send_valid, out_payload_lo, out_payload_mid, out_payload_hi,
           out_seq, out_ack, out_checksum, dropped, waiting,
    input  ready
  );
  modport sink (
    input  valid, send_valid, out_payload_lo, out_payload_mid, out_payload_hi,
           out_seq, out_ack, out_checksum, dropped, waiting,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/alternating_bit_sender_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Sender side of the alternating-bit protocol. Every input transfer (message,
// acknowledgement or timer tick) yields exactly one result transfer. It passes
// the input stage, where the payload is trimmed to PAYLOAD_BYTES and its
// byte checksum is formed, then the protocol stage, which lands in the result
// register. A new item is taken every cycle while the result side keeps up.
// Messages that arrive while a packet is outstanding are held, with their
// checksum, in a QUEUE_DEPTH-entry memory, or dropped if it is full; the
// entry at the queue head is read every cycle, with the write in the same
// cycle forwarded, so a good acknowledgement sends the next message at once.
// The queue needs no clearing after reset. The user must write timeout_ticks
// (cfg_we/cfg_wdata) only while the block is idle; it is not enforced.
module alternating_bit_sender_top #(
  parameter int QUEUE_DEPTH   = 128,
  parameter int PAYLOAD_BYTES = 20
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [abs_pkg::TIMEOUT_W-1:0] cfg_wdata,
  abs_in_if.sink                             in_ch,
  abs_out_if.source                          out_ch
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int BYTES = abs_pkg::PL_BYTES;

  function automatic abs_pkg::payload_t trim(input abs_pkg::payload_t pl);
    abs_pkg::payload_t r;
    r = pl;
    for (int i = 0; i < BYTES; i++) begin
      if (i >= PAYLOAD_BYTES) r[8*i +: 8] = 8'd0;
    end
    return r;
  endfunction

  function automatic abs_pkg::chk_t byte_sum(input abs_pkg::payload_t pl);
    abs_pkg::chk_t part [BYTES];
    logic          alive;
    alive = 1'b1;
    for (int i = 0; i < BYTES; i++) begin
      alive   = alive & (pl[8*i +: 8] != 8'd0);
      part[i] = alive ? abs_pkg::chk_t'(pl[8*i +: 8]) : '0;
    end
    for (int w = 1; w < BYTES; w = w * 2) begin
      for (int i = 0; i + w < BYTES; i = i + 2 * w) begin
        part[i] = part[i] + part[i + w];
      end
    end
    return part[0];
  endfunction

  // input stage
  logic                        s1_v_r;
  logic [abs_pkg::MODE_W-1:0]  s1_mode_r;
  abs_pkg::payload_t           s1_pl_r;
  abs_pkg::chk_t               s1_chk_r;
  logic                        s1_ack_r;
  abs_pkg::chk_t               s1_cin_r;
  abs_pkg::payload_t           in_pl;
  abs_pkg::chk_t               in_sum;

  // protocol state
  abs_pkg::ticks_t             timeout_r;
  abs_pkg::payload_t           cur_pl_r, cur_pl_nxt;
  abs_pkg::chk_t               cur_chk_r, cur_chk_nxt;
  logic                        seq_r, seq_nxt;
  logic                        busy_r, busy_nxt;
  abs_pkg::ticks_t             cnt_r, cnt_nxt;
  logic [PTR_W-1:0]            head_r, head_nxt;
  logic [PTR_W-1:0]            tail_r, tail_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;

  // queue memory
  abs_pkg::entry_t             mem [QUEUE_DEPTH];
  abs_pkg::entry_t             rdata_r;
  abs_pkg::entry_t             wdata;
  logic                        mem_we;

  // result register
  logic                        out_v_r;
  logic                        res_send_r;
  abs_pkg::payload_t           res_pl_r;
  logic                        res_seq_r;
  abs_pkg::chk_t               res_chk_r;
  logic                        res_drop_r;
  logic                        res_wait_r;

  logic                        fire;
  logic                        in_ready;
  logic                        start_en;
  logic                        resend;
  logic                        drop;
  abs_pkg::entry_t             start_e;

  assign fire     = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ready = !s1_v_r || fire;
  assign in_ch.ready = in_ready;

  assign in_pl  = trim({in_ch.payload_hi, in_ch.payload_mid, in_ch.payload_lo});
  assign in_sum = byte_sum(in_pl);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_ch.valid;
    end
    if (in_ch.valid && in_ready) begin
      s1_mode_r <= in_ch.mode;
      s1_pl_r   <= in_pl;
      s1_ack_r  <= in_ch.ack_number;
      s1_cin_r  <= in_ch.checksum_in;
      if (in_ch.mode == abs_pkg::MODE_ACK) begin
        s1_chk_r <= in_sum + abs_pkg::chk_t'(in_ch.ack_number)
                           + abs_pkg::chk_t'(in_ch.seq_number);
      end else begin
        s1_chk_r <= in_sum;
      end
    end
  end

  assign wdata = '{pl: s1_pl_r, chk: s1_chk_r};

  always_comb begin
    cur_pl_nxt  = cur_pl_r;
    cur_chk_nxt = cur_chk_r;
    seq_nxt     = seq_r;
    busy_nxt    = busy_r;
    cnt_nxt     = cnt_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    mem_we      = 1'b0;
    start_en    = 1'b0;
    resend      = 1'b0;
    drop        = 1'b0;
    start_e     = wdata;
    if (fire) begin
      case (s1_mode_r)
        abs_pkg::MODE_MSG: begin
          if (!busy_r) begin
            start_en = 1'b1;
          end else if (count_r < CNT_W'(QUEUE_DEPTH)) begin
            mem_we    = 1'b1;
            tail_nxt  = (tail_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
            count_nxt = count_r + 1'b1;
          end else begin
            drop = 1'b1;
          end
        end
        abs_pkg::MODE_ACK: begin
          if (busy_r) begin
            if (s1_ack_r == seq_r && s1_cin_r == s1_chk_r) begin
              busy_nxt = 1'b0;
              cnt_nxt  = '0;
              if (count_r != '0) begin
                start_en  = 1'b1;
                start_e   = rdata_r;
                head_nxt  = (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
                count_nxt = count_r - 1'b1;
              end
            end else begin
              resend = 1'b1;
            end
          end
        end
        abs_pkg::MODE_TICK: begin
          if (busy_r) begin
            if (cnt_r > abs_pkg::ticks_t'(1)) begin
              cnt_nxt = cnt_r - 1'b1;
            end else begin
              resend = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
      if (start_en) begin
        cur_pl_nxt  = start_e.pl;
        cur_chk_nxt = start_e.chk;
        seq_nxt     = ~seq_r;
        busy_nxt    = 1'b1;
        cnt_nxt     = timeout_r;
      end
      if (resend) begin
        cnt_nxt = timeout_r;
      end
    end
  end

  // head entry is read every cycle; forward a same-cycle write to it
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail_r] <= wdata;
    end
    if (mem_we && tail_r == head_nxt) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[head_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r  <= abs_pkg::TIMEOUT_RESET;
      cur_pl_r   <= '0;
      cur_chk_r  <= '0;
      seq_r      <= 1'b1;
      busy_r     <= 1'b0;
      cnt_r      <= '0;
      head_r     <= '0;
      tail_r     <= '0;
      count_r    <= '0;
      out_v_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        timeout_r <= cfg_wdata;
      end
      cur_pl_r  <= cur_pl_nxt;
      cur_chk_r <= cur_chk_nxt;
      seq_r     <= seq_nxt;
      busy_r    <= busy_nxt;
      cnt_r     <= cnt_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      count_r   <= count_nxt;
      if (fire) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_send_r <= start_en | resend;
      res_pl_r   <= (start_en | resend) ? cur_pl_nxt : '0;
      res_seq_r  <= (start_en | resend) ? seq_nxt : 1'b0;
      res_chk_r  <= (start_en | resend) ? cur_chk_nxt : '0;
      res_drop_r <= drop;
      res_wait_r <= busy_nxt;
    end
  end

  assign out_ch.valid           = out_v_r;
  assign out_ch.send_valid      = res_send_r;
  assign out_ch.out_payload_lo  = res_pl_r[abs_pkg::LO_W-1:0];
  assign out_ch.out_payload_mid = res_pl_r[abs_pkg::LO_W +: abs_pkg::MID_W];
  assign out_ch.out_payload_hi  = res_pl_r[abs_pkg::LO_W + abs_pkg::MID_W +: abs_pkg::HI_W];
  assign out_ch.out_seq         = res_seq_r;
  assign out_ch.out_ack         = 1'b0;
  assign out_ch.out_checksum    = res_chk_r;
  assign out_ch.dropped         = res_drop_r;
  assign out_ch.waiting         = res_wait_r;

endmodule

`default_nettype wire
